>>> src/ccrk_pkg.sv
package ccrk_pkg;

  // alphabet and ascii anchors
  localparam int unsigned ALPHA_SIZE = 26;
  localparam int unsigned LETTER_W = 5;
  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA_SIZE - 1);
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

  // register reset value: 'e'
  localparam logic [4:0] REF_LETTER_RESET = 5'd4;

  // defaults for top level parameters
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // command and result kind codes
  localparam logic CMD_ANALYZE = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [4:0]  shift_found;
    logic [15:0] top_count;
  } out_item_t;

  // classified item travelling from front to back
  typedef struct packed {
    logic                cmd;
    logic                is_last;
    logic                is_letter;
    logic                is_upper;
    logic [LETTER_W-1:0] letter_idx;
    logic [7:0]          raw_byte;
  } q_entry_t;

endpackage

>>> src/caesar_frequency_cracker_unit.sv
// a decrypt byte passes the input queue and then the output register; a report follows
// its final analyze byte after the count, argmax walk and report states
// throughput: one item per cycle unless an output stall or the walk holds the back end,
// set by the single-ported histogram and queue head; a final analyze byte holds the back
// end for count, 26-step argmax walk and report; the input queue takes items until it fills
// reset: synchronous active-low rst_n clears counters, queue, shift and output valid,
// and sets the reference letter to 'e'
module caesar_frequency_cracker_unit #(
  parameter int unsigned COUNT_WIDTH = ccrk_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = ccrk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccrk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccrk_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data
);
  import ccrk_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  // accept and classify
  ccrk_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // decoupling queue
  ccrk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // histogram, argmax and decrypt
  ccrk_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> src/ccrk_front.sv
module ccrk_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  ccrk_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output ccrk_pkg::q_entry_t q_wdata
);
  import ccrk_pkg::*;

  logic upper_hit;
  logic lower_hit;

  // letter detection on raw byte
  assign upper_hit = (in_data.in_byte >= ASCII_UPPER_A) && (in_data.in_byte <= ASCII_UPPER_Z);
  assign lower_hit = (in_data.in_byte >= ASCII_LOWER_A) && (in_data.in_byte <= ASCII_LOWER_Z);

  // accept while queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classified entry
  always_comb begin
    q_wdata.cmd       = in_data.cmd;
    q_wdata.is_last   = in_data.is_last;
    q_wdata.is_letter = upper_hit || lower_hit;
    q_wdata.is_upper  = upper_hit;
    q_wdata.raw_byte  = in_data.in_byte;
    if (upper_hit) begin
      q_wdata.letter_idx = LETTER_W'(in_data.in_byte - ASCII_UPPER_A);
    end else if (lower_hit) begin
      q_wdata.letter_idx = LETTER_W'(in_data.in_byte - ASCII_LOWER_A);
    end else begin
      q_wdata.letter_idx = '0;
    end
  end

endmodule

>>> src/ccrk_fifo.sv
module ccrk_fifo #(
  parameter int unsigned DEPTH = ccrk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ccrk_pkg::q_entry_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               rvalid,
  output ccrk_pkg::q_entry_t rdata
);
  import ccrk_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  q_entry_t           store_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   fill_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign rvalid  = (fill_r != '0);
  assign rdata   = store_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/ccrk_back.sv
module ccrk_back #(
  parameter int unsigned COUNT_WIDTH = ccrk_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic                q_valid,
  input  ccrk_pkg::q_entry_t  q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ccrk_pkg::out_item_t out_data
);
  import ccrk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t                  state_r;
  state_t                  state_nxt;
  logic [COUNT_WIDTH-1:0]  counts_r [ALPHA_SIZE];
  logic [4:0]              ref_letter_r;
  logic [LETTER_W-1:0]     shift_r;
  logic [LETTER_W-1:0]     shift_nxt;
  logic [LETTER_W-1:0]     walk_idx_r;
  logic [LETTER_W-1:0]     walk_idx_nxt;
  logic [LETTER_W-1:0]     best_idx_r;
  logic [LETTER_W-1:0]     best_idx_nxt;
  logic [COUNT_WIDTH-1:0]  best_cnt_r;
  logic [COUNT_WIDTH-1:0]  best_cnt_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  out_item_t               out_data_r;
  out_item_t               out_data_nxt;

  logic                    out_free;
  logic                    out_load;
  logic [LETTER_W-1:0]     rd_idx;
  logic [COUNT_WIDTH-1:0]  rd_cnt;
  logic                    cnt_we;
  logic                    cnt_clr;
  logic [LETTER_W-1:0]     ref_mod;
  logic [LETTER_W:0]       est_shift;
  logic [LETTER_W:0]       dec_idx;
  logic [31:0]             best_cnt_ext;
  logic [15:0]             top_cnt;
  logic [7:0]              dec_byte;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // single counter read port, shared by increment and walk
  assign rd_idx = (state_r == ST_WALK) ? walk_idx_r : q_rdata.letter_idx;
  assign rd_cnt = counts_r[rd_idx];

  // reference folded into 0..25
  assign ref_mod = (ref_letter_r >= 5'(ALPHA_SIZE)) ? ref_letter_r - 5'(ALPHA_SIZE)
                                                   : ref_letter_r;

  // shift = (best - ref) mod 26
  assign est_shift = (best_idx_r >= ref_mod)
                   ? {1'b0, best_idx_r} - {1'b0, ref_mod}
                   : {1'b0, best_idx_r} + 6'(ALPHA_SIZE) - {1'b0, ref_mod};

  // winning count clipped to 16 bits
  assign best_cnt_ext = 32'(best_cnt_r);
  assign top_cnt = (best_cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : best_cnt_ext[15:0];

  // decrypt: shift letter back, keep case
  assign dec_idx = (q_rdata.letter_idx >= shift_r)
                 ? {1'b0, q_rdata.letter_idx} - {1'b0, shift_r}
                 : {1'b0, q_rdata.letter_idx} + 6'(ALPHA_SIZE) - {1'b0, shift_r};

  always_comb begin
    if (!q_rdata.is_letter) begin
      dec_byte = q_rdata.raw_byte;
    end else if (q_rdata.is_upper) begin
      dec_byte = ASCII_UPPER_A + {3'b000, dec_idx[LETTER_W-1:0]};
    end else begin
      dec_byte = ASCII_LOWER_A + {3'b000, dec_idx[LETTER_W-1:0]};
    end
  end

  // sequencer: count or decrypt, walk for argmax, report
  always_comb begin
    state_nxt    = state_r;
    walk_idx_nxt = walk_idx_r;
    best_idx_nxt = best_idx_r;
    best_cnt_nxt = best_cnt_r;
    shift_nxt    = shift_r;
    q_pop        = 1'b0;
    cnt_we       = 1'b0;
    cnt_clr      = 1'b0;
    out_load     = 1'b0;
    out_data_nxt = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_rdata.cmd == CMD_DECRYPT) begin
            if (out_free) begin
              q_pop                    = 1'b1;
              out_load                 = 1'b1;
              out_data_nxt.kind        = KIND_BYTE;
              out_data_nxt.out_byte    = dec_byte;
              out_data_nxt.shift_found = shift_r;
              out_data_nxt.top_count   = '0;
            end
          end else begin
            q_pop  = 1'b1;
            cnt_we = q_rdata.is_letter && (rd_cnt != COUNT_MAX);
            if (q_rdata.is_last) begin
              state_nxt    = ST_WALK;
              walk_idx_nxt = '0;
              best_idx_nxt = '0;
              best_cnt_nxt = '0;
            end
          end
        end
      end
      ST_WALK: begin
        if (rd_cnt > best_cnt_r) begin
          best_idx_nxt = walk_idx_r;
          best_cnt_nxt = rd_cnt;
        end
        if (walk_idx_r == LAST_LETTER) begin
          state_nxt = ST_REPORT;
        end else begin
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_load                 = 1'b1;
          cnt_clr                  = 1'b1;
          shift_nxt                = est_shift[LETTER_W-1:0];
          out_data_nxt.kind        = KIND_REPORT;
          out_data_nxt.out_byte    = '0;
          out_data_nxt.shift_found = est_shift[LETTER_W-1:0];
          out_data_nxt.top_count   = top_cnt;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and latched state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      shift_r      <= '0;
      ref_letter_r <= REF_LETTER_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ref_letter_r <= cfg_wr_data;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // letter histogram
  always_ff @(posedge clk) begin
    if (!rst_n || cnt_clr) begin
      for (int i = 0; i < ALPHA_SIZE; i++) begin
        counts_r[i] <= '0;
      end
    end else if (cnt_we) begin
      counts_r[rd_idx] <= rd_cnt + 1'b1;
    end
  end

endmodule

>>> tb/caesar_frequency_cracker_unit_test.sv
module caesar_frequency_cracker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccrk_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_CHUNK = 310;
  localparam int LONG_HOLD = 300;
  localparam int MAX_PRINTED = 50;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  caesar_frequency_cracker_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow state of the cracker
  logic [15:0] tally [ALPHA_SIZE];
  logic [4:0]  shift_latched;
  logic [4:0]  ref_letter;

  in_item_t  text_queue [$];
  out_item_t expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit in_taken = 1'b0;
  int idle_cycles = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_reports = 0;
  int n_bytes = 0;
  int n_cfg = 0;

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int letter_of(input logic [7:0] b);
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) return int'(b - ASCII_UPPER_A);
    if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) return int'(b - ASCII_LOWER_A);
    return -1;
  endfunction

  function automatic logic [7:0] rand_letter(input int idx);
    if ($urandom_range(1) == 1) return ASCII_UPPER_A + 8'(idx);
    return ASCII_LOWER_A + 8'(idx);
  endfunction

  task automatic reset_shadow();
    foreach (tally[i]) tally[i] = '0;
    shift_latched = '0;
    ref_letter = REF_LETTER_RESET;
  endtask

  // histogram, argmax and decrypt, one transaction at a time
  task automatic crack_text(input in_item_t it);
    int li;
    int best;
    int refl;
    logic [15:0] best_cnt;
    out_item_t res;
    li = letter_of(it.in_byte);
    res = '0;
    if (it.cmd == CMD_DECRYPT) begin
      res.kind = KIND_BYTE;
      res.out_byte = it.in_byte;
      if (li >= 0) begin
        res.out_byte = ((it.in_byte <= ASCII_UPPER_Z) ? ASCII_UPPER_A : ASCII_LOWER_A)
                       + 8'((li + ALPHA_SIZE - shift_latched) % ALPHA_SIZE);
      end
      res.shift_found = shift_latched;
      expected_results.push_back(res);
    end else begin
      if (li >= 0 && tally[li] != '1) tally[li] = tally[li] + 16'd1;
      if (it.is_last) begin
        best = 0;
        best_cnt = tally[0];
        for (int i = 1; i < ALPHA_SIZE; i++) begin
          if (tally[i] > best_cnt) begin
            best_cnt = tally[i];
            best = i;
          end
        end
        refl = ref_letter % ALPHA_SIZE;
        shift_latched = 5'((best + ALPHA_SIZE - refl) % ALPHA_SIZE);
        res.kind = KIND_REPORT;
        res.shift_found = shift_latched;
        res.top_count = best_cnt;
        foreach (tally[i]) tally[i] = '0;
        expected_results.push_back(res);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at %0t: %s got 0x%0h wanted 0x%0h", $time, what, got, want);
  endtask

  // monitor: check results, then predict from accepted input
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (want.kind == KIND_REPORT) n_reports++;
          else n_bytes++;
          if (out_data.kind !== want.kind)
            report_mismatch("kind", 32'(out_data.kind), 32'(want.kind));
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
          if (out_data.shift_found !== want.shift_found)
            report_mismatch("shift_found", 32'(out_data.shift_found), 32'(want.shift_found));
          if (out_data.top_count !== want.top_count)
            report_mismatch("top_count", 32'(out_data.top_count), 32'(want.top_count));
        end
      end
      if (in_taken) begin
        crack_text(in_data);
        n_items++;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // input driver, holds the item until it is taken
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= text_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output ready, with random gaps and long holds on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_text(input logic cmd, input logic [7:0] b, input logic last);
    in_item_t it;
    it.cmd = cmd;
    it.in_byte = b;
    it.is_last = last;
    text_queue.push_back(it);
  endtask

  task automatic wait_drained();
    while (text_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reference(input logic [4:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ref_letter = value;
    n_cfg++;
    @(posedge clk);
  endtask

  // mostly whole messages: analyze run, last byte, then decrypt bytes
  task automatic queue_random_text(input int n_items);
    int added;
    int len;
    int n_dec;
    int lead;
    logic [7:0] b;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(99) < 78) begin
        lead = $urandom_range(ALPHA_SIZE - 1);
        len = $urandom_range(24);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(3))
            0, 1: b = rand_letter(lead);
            2: b = rand_letter($urandom_range(ALPHA_SIZE - 1));
            default: b = 8'($urandom_range(255));
          endcase
          push_text(CMD_ANALYZE, b, 1'b0);
        end
        push_text(CMD_ANALYZE, 8'($urandom_range(255)), 1'b1);
        n_dec = $urandom_range(12);
        for (int i = 0; i < n_dec; i++) begin
          if ($urandom_range(9) < 7) b = rand_letter($urandom_range(ALPHA_SIZE - 1));
          else b = 8'($urandom_range(255));
          push_text(CMD_DECRYPT, b, 1'($urandom_range(1)));
        end
        added += len + 1 + n_dec;
      end else begin
        push_text(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        added++;
      end
    end
  endtask

  // stimulus sequence
  initial begin
    int ref_settings [6];
    reset_shadow();
    send_idle_pct = 35;
    recv_idle_pct = 53;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decrypt with the reset shift, is_last ignored on decrypt
    push_text(CMD_DECRYPT, "A", 1'b0);
    push_text(CMD_DECRYPT, "z", 1'b0);
    push_text(CMD_DECRYPT, 8'h00, 1'b0);
    push_text(CMD_DECRYPT, 8'hFF, 1'b1);
    // empty histogram gives 'a' with count zero
    push_text(CMD_ANALYZE, 8'h00, 1'b1);
    // bytes just outside the letter ranges pass through, edge letters decrypt
    push_text(CMD_DECRYPT, 8'h40, 1'b0);
    push_text(CMD_DECRYPT, 8'h5B, 1'b0);
    push_text(CMD_DECRYPT, 8'h60, 1'b0);
    push_text(CMD_DECRYPT, 8'h7B, 1'b0);
    push_text(CMD_DECRYPT, "a", 1'b0);
    push_text(CMD_DECRYPT, "Z", 1'b0);
    // tie between b and c goes to b, non-letter last byte
    push_text(CMD_ANALYZE, "c", 1'b0);
    push_text(CMD_ANALYZE, "B", 1'b0);
    push_text(CMD_ANALYZE, "b", 1'b0);
    push_text(CMD_ANALYZE, "C", 1'b0);
    push_text(CMD_ANALYZE, "Z", 1'b0);
    push_text(CMD_ANALYZE, 8'h7E, 1'b1);
    push_text(CMD_DECRYPT, "M", 1'b0);
    push_text(CMD_DECRYPT, "y", 1'b0);
    push_text(CMD_DECRYPT, 8'h80, 1'b0);
    // letter last byte counted before the estimate
    push_text(CMD_ANALYZE, "e", 1'b0);
    push_text(CMD_ANALYZE, "E", 1'b0);
    push_text(CMD_ANALYZE, "e", 1'b1);
    wait_drained();

    ref_settings = '{0, 25, 31, 26, 0, 13};
    ref_settings[4] = $urandom_range(31);
    for (int k = 0; k < 6; k++) begin
      write_reference(5'(ref_settings[k]));
      case (k / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      queue_random_text(ITEMS_PER_CHUNK);
      // long output hold so the block backs up into its input
      if (k == 1) begin
        @(posedge clk);
        hold_request = LONG_HOLD;
      end
      wait_drained();
    end

    if (expected_results.size() != 0)
      report_mismatch("results never seen", 32'(expected_results.size()), 32'd0);
    $display("run covered %0d text bytes, %0d shift reports and %0d decrypted bytes",
             n_items, n_reports, n_bytes);
    $display("%0d reference letter writes, three idle mixes and a long output hold",
             n_cfg);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
